// ===== design/blms_pkg.sv =====
package blms_pkg;

   // Geometry
   localparam int NUM_COLOURS_DEF = 3;
   localparam int ROWS            = 8;
   localparam int ROW_AW          = 3;
   localparam int COLOUR_W        = 2;
   localparam int COL_W           = 2;
   localparam int LED_LANES       = 6;

   // Configuration port
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   localparam logic [1:0] CSR_DEBOUNCE_DELAY  = 2'd0;
   localparam logic [1:0] CSR_CATHODE_INVERT  = 2'd1;
   localparam logic [1:0] CSR_DIN_ENABLE      = 2'd2;

   localparam logic [1:0] DIN_ENABLE_RST = 2'b11;

   // Request codes
   localparam logic [2:0] REQ_SCAN   = 3'd0;
   localparam logic [2:0] REQ_BIT_WR = 3'd1;
   localparam logic [2:0] REQ_ROW_WR = 3'd2;
   localparam logic [2:0] REQ_ROW_RD = 3'd3;
   localparam logic [2:0] REQ_BTN_RD = 3'd4;
   localparam logic [2:0] REQ_DRAIN  = 3'd5;

   // Result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_RANGE    = 2'd1;
   localparam logic [1:0] ST_COLOUR   = 2'd2;
   localparam logic [1:0] ST_NO_EVENT = 2'd3;

   localparam logic [7:0] ABSENT_BYTE = 8'hFF;
   localparam logic [3:0] NIBBLE_MASK = 4'hF;

   typedef struct packed {
      logic load_req;
      logic scan_col;
      logic led_step;
      logic deb_left;
      logic deb_right;
      logic mem_rd_req;
      logic mem_wr_row;
      logic mem_wr_bit;
      logic rd_cap;
      logic btn_cap;
      logic drain_next;
      logic drain_emit;
      logic out_result;
   } blms_cmd_type;

   typedef struct packed {
      logic [2:0] req_type;
      logic       req_err;
      logic       led_done;
      logic       out_free;
      logic       row_empty;
      logic       event_last;
   } blms_stat_type;

endpackage

// ===== design/button_led_matrix_scanner.sv =====
// Button and LED matrix scanner, 4 columns by 8 rows of 8 bits. One item is
// worked at a time: an item is taken from req_ when the block is idle, and
// its results leave through a one-deep output register on rsp_, so the next
// item is taken while the last result still waits. A scan item goes through
// decode, the column step, 2*NUM_COLOURS reads from the single-port LED
// plane memory (one byte a cycle, pipelined), one step per debounce side
// and one to load the result. LED bit writes and row reads read, then
// modify or capture; row writes, button row reads and failing requests go
// from decode to the result. A drain item gives one result per pending
// change, one a cycle while the output is free, skipping rows without changes.
// Unknown request codes are dropped with no result. Results only move when
// rsp_stall is low. After reset there is no clearing pass: LED entries that
// were never written read as zero through per-entry valid flags.
//
// Scan: the column advances (wrapping after 3), the cathode byte is the
// inverted one-hot column in both nibbles XOR cathode_invert_mask, and the
// LED bytes of the new column are returned for each fitted colour (unfitted
// colours give 0). The sampled button bytes are then debounced into the
// two rows of the previous column. A single shared counter is decremented
// once per scan and reloaded with debounce_delay on any change, so a left
// side change with nonzero delay masks the right side of the same scan.
// A side disabled in din_enable reads as all ones.
//
// Config registers (APB, byte addresses): 0x0 debounce_delay,
// 0x4 cathode_invert_mask, 0x8 din_enable (reset 3). Write only while idle.
module button_led_matrix_scanner
   import blms_pkg::*;
#(
   parameter int NUM_COLOURS = NUM_COLOURS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_type,
   input  logic [7:0]          req_din_left,
   input  logic [7:0]          req_din_right,
   input  logic [COLOUR_W-1:0] req_colour,
   input  logic [7:0]          req_pin,
   input  logic [3:0]          req_row,
   input  logic [7:0]          req_value,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_cathode_drive,
   output logic [7:0]          rsp_led_left_c0,
   output logic [7:0]          rsp_led_right_c0,
   output logic [7:0]          rsp_led_left_c1,
   output logic [7:0]          rsp_led_right_c1,
   output logic [7:0]          rsp_led_left_c2,
   output logic [7:0]          rsp_led_right_c2,
   output logic [7:0]          rsp_read_data,
   output logic [5:0]          rsp_event_pin,
   output logic                rsp_event_value,
   output logic [1:0]          rsp_status,
   output logic                rsp_last,
   // config port
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CSR_AW-1:0]   csr_paddr,
   input  logic [CSR_DW-1:0]   csr_pwdata,
   output logic [CSR_DW-1:0]   csr_prdata,
   output logic                csr_pready
);

   blms_cmd_type  cmd;
   blms_stat_type stat;

   logic [7:0] debounce_delay_ff;
   logic [7:0] cathode_invert_ff;
   logic [1:0] din_enable_ff;
   logic [1:0] csr_idx;
   logic       csr_wr;

   // ---- config registers: word index from paddr[3:2], pready tied high
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_delay_ff <= 8'h00;
         cathode_invert_ff <= 8'h00;
         din_enable_ff     <= DIN_ENABLE_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_DEBOUNCE_DELAY: debounce_delay_ff <= csr_pwdata[7:0];
            CSR_CATHODE_INVERT: cathode_invert_ff <= csr_pwdata[7:0];
            CSR_DIN_ENABLE:     din_enable_ff     <= csr_pwdata[1:0];
            default:            ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_DEBOUNCE_DELAY: csr_prdata = {{(CSR_DW-8){1'b0}}, debounce_delay_ff};
         CSR_CATHODE_INVERT: csr_prdata = {{(CSR_DW-8){1'b0}}, cathode_invert_ff};
         CSR_DIN_ENABLE:     csr_prdata = {{(CSR_DW-2){1'b0}}, din_enable_ff};
         default:            csr_prdata = '0;
      endcase
   end

   // ---- sequencer
   blms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // ---- storage, debounce, drain walk and output register
   blms_dp #(
      .NUM_COLOURS (NUM_COLOURS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_type            (req_type),
      .req_din_left        (req_din_left),
      .req_din_right       (req_din_right),
      .req_colour          (req_colour),
      .req_pin             (req_pin),
      .req_row             (req_row),
      .req_value           (req_value),
      .debounce_delay      (debounce_delay_ff),
      .cathode_invert_mask (cathode_invert_ff),
      .din_enable          (din_enable_ff),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_cathode_drive   (rsp_cathode_drive),
      .rsp_led_left_c0     (rsp_led_left_c0),
      .rsp_led_right_c0    (rsp_led_right_c0),
      .rsp_led_left_c1     (rsp_led_left_c1),
      .rsp_led_right_c1    (rsp_led_right_c1),
      .rsp_led_left_c2     (rsp_led_left_c2),
      .rsp_led_right_c2    (rsp_led_right_c2),
      .rsp_read_data       (rsp_read_data),
      .rsp_event_pin       (rsp_event_pin),
      .rsp_event_value     (rsp_event_value),
      .rsp_status          (rsp_status),
      .rsp_last            (rsp_last)
   );

   // ---- checks

   // one item in work at a time: taking an item closes the input
   a_single_item : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item taken while another is in work");

   // a new result only appears out of an item that was in work
   a_result_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without an item in work");

   // any non-ok status is a single, final result
   a_error_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |-> rsp_last)
      else $error("error result not marked last");

   // failing requests return no data
   a_error_no_data : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_RANGE || rsp_status == ST_COLOUR))
         |-> (rsp_read_data == 8'h00 && rsp_cathode_drive == 8'h00))
      else $error("failing request returned data");

endmodule

// ===== design/blms_ctrl.sv =====
module blms_ctrl
   import blms_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  blms_stat_type stat,
   output blms_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_LED,
      S_DEB_L,
      S_DEB_R,
      S_BIT_WR,
      S_RD_CAP,
      S_EMIT,
      S_DRAIN
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.req_err) begin
               state_in = S_EMIT;
            end else begin
               case (stat.req_type)
                  REQ_SCAN:   state_in = S_SCAN;
                  REQ_BIT_WR: begin
                     cmd.mem_rd_req = 1'b1;
                     state_in       = S_BIT_WR;
                  end
                  REQ_ROW_WR: begin
                     cmd.mem_wr_row = 1'b1;
                     state_in       = S_EMIT;
                  end
                  REQ_ROW_RD: begin
                     cmd.mem_rd_req = 1'b1;
                     state_in       = S_RD_CAP;
                  end
                  REQ_BTN_RD: begin
                     cmd.btn_cap = 1'b1;
                     state_in    = S_EMIT;
                  end
                  REQ_DRAIN:  state_in = S_DRAIN;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_SCAN: begin
            cmd.scan_col = 1'b1;
            state_in     = S_LED;
         end
         S_LED: begin
            cmd.led_step = 1'b1;
            if (stat.led_done) begin
               state_in = S_DEB_L;
            end
         end
         S_DEB_L: begin
            cmd.deb_left = 1'b1;
            state_in     = S_DEB_R;
         end
         S_DEB_R: begin
            cmd.deb_right = 1'b1;
            state_in      = S_EMIT;
         end
         S_BIT_WR: begin
            cmd.mem_wr_bit = 1'b1;
            state_in       = S_EMIT;
         end
         S_RD_CAP: begin
            cmd.rd_cap = 1'b1;
            state_in   = S_EMIT;
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.out_result = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_DRAIN: begin
            if (stat.row_empty) begin
               cmd.drain_next = 1'b1;
            end else if (stat.out_free) begin
               cmd.drain_emit = 1'b1;
               if (stat.event_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

// ===== design/blms_dp.sv =====
module blms_dp
   import blms_pkg::*;
#(
   parameter int NUM_COLOURS = NUM_COLOURS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  blms_cmd_type        cmd,
   output blms_stat_type       stat,
   // latched request fields
   input  logic [2:0]          req_type,
   input  logic [7:0]          req_din_left,
   input  logic [7:0]          req_din_right,
   input  logic [COLOUR_W-1:0] req_colour,
   input  logic [7:0]          req_pin,
   input  logic [3:0]          req_row,
   input  logic [7:0]          req_value,
   // configuration
   input  logic [7:0]          debounce_delay,
   input  logic [7:0]          cathode_invert_mask,
   input  logic [1:0]          din_enable,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_cathode_drive,
   output logic [7:0]          rsp_led_left_c0,
   output logic [7:0]          rsp_led_right_c0,
   output logic [7:0]          rsp_led_left_c1,
   output logic [7:0]          rsp_led_right_c1,
   output logic [7:0]          rsp_led_left_c2,
   output logic [7:0]          rsp_led_right_c2,
   output logic [7:0]          rsp_read_data,
   output logic [5:0]          rsp_event_pin,
   output logic                rsp_event_value,
   output logic [1:0]          rsp_status,
   output logic                rsp_last
);

   localparam int MEM_DEPTH = NUM_COLOURS * ROWS;
   localparam int MEM_AW    = $clog2(MEM_DEPTH);
   localparam int LED_READS = 2 * NUM_COLOURS;
   localparam int SLOT_W    = $clog2(LED_READS + 1);

   // latched request
   logic [2:0]          lat_type_ff;
   logic [7:0]          lat_din_left_ff;
   logic [7:0]          lat_din_right_ff;
   logic [COLOUR_W-1:0] lat_colour_ff;
   logic [7:0]          lat_pin_ff;
   logic [3:0]          lat_row_ff;
   logic [7:0]          lat_value_ff;

   // block state
   logic [COL_W-1:0]    column_ff;
   logic [7:0]          deb_cnt_ff;
   logic [7:0]          btn_ff   [ROWS];
   logic [7:0]          flags_ff [ROWS];

   // LED plane memory
   logic [7:0]           led_mem [MEM_DEPTH];
   logic [MEM_DEPTH-1:0] led_vld_ff;
   logic [7:0]           rd_data_ff;
   logic                 rd_vld_ff;

   // working result
   logic [SLOT_W-1:0]   slot_ff;
   logic [7:0]          lane_ff [LED_LANES];
   logic [7:0]          drive_ff;
   logic [7:0]          res_read_ff;
   logic [ROW_AW-1:0]   dr_ff;

   // output register
   logic                rsp_valid_ff;
   logic [7:0]          out_drive_ff;
   logic [7:0]          out_led_ff [LED_LANES];
   logic [7:0]          out_read_ff;
   logic [5:0]          out_pin_ff;
   logic                out_val_ff;
   logic [1:0]          out_status_ff;
   logic                out_last_ff;

   logic [COL_W-1:0]    col_next;
   logic [COL_W-1:0]    col_prev;
   logic [3:0]          col_onehot;
   logic [3:0]          drive_nib;
   logic [ROW_AW-1:0]   req_row_idx;
   logic [MEM_AW-1:0]   req_addr;
   logic [MEM_AW-1:0]   scan_addr;
   logic [MEM_AW-1:0]   mem_rd_addr;
   logic                mem_rd_en;
   logic                mem_wr_en;
   logic [7:0]          mem_wr_data;
   logic [7:0]          mem_rd_word;
   logic [7:0]          bit_mask;
   logic [7:0]          bit_word;
   logic [ROW_AW-1:0]   btn_addr;
   logic [7:0]          btn_rd;
   logic [7:0]          flags_rd;
   logic [7:0]          din_sel;
   logic [7:0]          deb_change;
   logic                deb_go;
   logic [2:0]          low_idx;
   logic [7:0]          low_mask;
   logic                later_any;
   logic                flags_any;
   logic                event_last;
   logic [1:0]          req_status;
   logic                out_free;

   // ---------------------------------------------------------------- decode
   assign col_next   = column_ff + COL_W'(1);
   assign col_prev   = column_ff - COL_W'(1);
   assign col_onehot = 4'b0001 << col_next;
   assign drive_nib  = col_onehot ^ NIBBLE_MASK;

   assign req_row_idx = (lat_type_ff == REQ_BIT_WR) ? lat_pin_ff[5:3] : lat_row_ff[2:0];
   assign req_addr    = MEM_AW'({lat_colour_ff, req_row_idx});
   assign scan_addr   = MEM_AW'({COLOUR_W'(slot_ff >> 1), column_ff, slot_ff[0]});

   always_comb begin
      req_status = ST_OK;
      case (lat_type_ff)
         REQ_BIT_WR: begin
            if (lat_pin_ff[7:6] != 2'b00) begin
               req_status = ST_RANGE;
            end else if (int'(lat_colour_ff) >= NUM_COLOURS) begin
               req_status = ST_COLOUR;
            end
         end
         REQ_ROW_WR, REQ_ROW_RD: begin
            if (lat_row_ff[3]) begin
               req_status = ST_RANGE;
            end else if (int'(lat_colour_ff) >= NUM_COLOURS) begin
               req_status = ST_COLOUR;
            end
         end
         REQ_BTN_RD: begin
            if (lat_row_ff[3]) begin
               req_status = ST_RANGE;
            end
         end
         REQ_DRAIN: begin
            if (!flags_any) begin
               req_status = ST_NO_EVENT;
            end
         end
         default: req_status = ST_OK;
      endcase
   end

   // ---------------------------------------------------------------- LED memory
   assign mem_rd_en   = (cmd.led_step && (int'(slot_ff) < LED_READS)) || cmd.mem_rd_req;
   assign mem_rd_addr = cmd.led_step ? scan_addr : req_addr;
   assign mem_rd_word = rd_vld_ff ? rd_data_ff : 8'h00;
   assign bit_mask    = 8'h01 << lat_pin_ff[2:0];
   assign bit_word    = lat_value_ff[0] ? (mem_rd_word | bit_mask) : (mem_rd_word & ~bit_mask);
   assign mem_wr_en   = cmd.mem_wr_row || cmd.mem_wr_bit;
   assign mem_wr_data = cmd.mem_wr_bit ? bit_word : lat_value_ff;

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         led_mem[req_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= led_mem[mem_rd_addr];
      end
   end

   // never-written entries read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         led_vld_ff <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         if (mem_wr_en) begin
            led_vld_ff[req_addr] <= 1'b1;
         end
         if (mem_rd_en) begin
            rd_vld_ff <= led_vld_ff[mem_rd_addr];
         end
      end
   end

   // ---------------------------------------------------------------- buttons
   always_comb begin
      if (cmd.deb_left || cmd.deb_right) begin
         btn_addr = {col_prev, cmd.deb_right};
      end else if (lat_type_ff == REQ_DRAIN) begin
         btn_addr = dr_ff;
      end else begin
         btn_addr = lat_row_ff[2:0];
      end
   end

   assign btn_rd   = btn_ff[btn_addr];
   assign flags_rd = flags_ff[btn_addr];

   always_comb begin
      if (cmd.deb_right) begin
         din_sel = din_enable[1] ? lat_din_right_ff : ABSENT_BYTE;
      end else begin
         din_sel = din_enable[0] ? lat_din_left_ff : ABSENT_BYTE;
      end
   end

   assign deb_change = din_sel ^ btn_rd;
   assign deb_go     = (cmd.deb_left || cmd.deb_right) && (deb_cnt_ff == 8'h00);

   // lowest pending bit of the drain row, and whether anything follows it
   always_comb begin
      low_idx = '0;
      for (int i = 7; i >= 0; i--) begin
         if (flags_rd[i]) begin
            low_idx = 3'(i);
         end
      end
   end

   assign low_mask = 8'h01 << low_idx;

   always_comb begin
      later_any = 1'b0;
      flags_any = 1'b0;
      for (int i = 0; i < ROWS; i++) begin
         if (flags_ff[i] != 8'h00) begin
            flags_any = 1'b1;
            if (i > int'(dr_ff)) begin
               later_any = 1'b1;
            end
         end
      end
   end

   assign event_last = ((flags_rd & ~low_mask) == 8'h00) && !later_any;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ROWS; i++) begin
            btn_ff[i]   <= ABSENT_BYTE;
            flags_ff[i] <= 8'h00;
         end
      end else if (deb_go) begin
         btn_ff[btn_addr]   <= din_sel;
         flags_ff[btn_addr] <= flags_rd | deb_change;
      end else if (cmd.drain_emit) begin
         flags_ff[btn_addr] <= flags_rd & ~low_mask;
      end
   end

   // ---------------------------------------------------------------- control state
   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff  <= '0;
         deb_cnt_ff <= 8'h00;
      end else begin
         if (cmd.scan_col) begin
            column_ff <= col_next;
         end
         if (cmd.scan_col && (deb_cnt_ff != 8'h00)) begin
            deb_cnt_ff <= deb_cnt_ff - 8'd1;
         end else if (deb_go && (deb_change != 8'h00)) begin
            deb_cnt_ff <= debounce_delay;
         end
      end
   end

   // ---------------------------------------------------------------- request and work regs
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         lat_type_ff      <= req_type;
         lat_din_left_ff  <= req_din_left;
         lat_din_right_ff <= req_din_right;
         lat_colour_ff    <= req_colour;
         lat_pin_ff       <= req_pin;
         lat_row_ff       <= req_row;
         lat_value_ff     <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         drive_ff    <= 8'h00;
         res_read_ff <= 8'h00;
         dr_ff       <= '0;
         for (int i = 0; i < LED_LANES; i++) begin
            lane_ff[i] <= 8'h00;
         end
      end else begin
         if (cmd.scan_col) begin
            drive_ff <= {drive_nib, drive_nib} ^ cathode_invert_mask;
         end
         if (cmd.rd_cap) begin
            res_read_ff <= mem_rd_word;
         end else if (cmd.btn_cap) begin
            res_read_ff <= btn_rd;
         end
         if (cmd.drain_next) begin
            dr_ff <= dr_ff + ROW_AW'(1);
         end
         // read data of slot i is registered and lands in lane i at slot i+1
         for (int i = 0; i < LED_LANES; i++) begin
            if (cmd.led_step && (int'(slot_ff) == i + 1)) begin
               lane_ff[i] <= mem_rd_word;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_col) begin
         slot_ff <= '0;
      end else if (cmd.led_step) begin
         slot_ff <= slot_ff + SLOT_W'(1);
      end
   end

   // ---------------------------------------------------------------- output register
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_result || cmd.drain_emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_result) begin
         out_drive_ff  <= drive_ff;
         out_read_ff   <= res_read_ff;
         out_pin_ff    <= 6'd0;
         out_val_ff    <= 1'b0;
         out_status_ff <= req_status;
         out_last_ff   <= 1'b1;
         for (int i = 0; i < LED_LANES; i++) begin
            out_led_ff[i] <= lane_ff[i];
         end
      end else if (cmd.drain_emit) begin
         out_drive_ff  <= 8'h00;
         out_read_ff   <= 8'h00;
         out_pin_ff    <= {dr_ff, low_idx};
         out_val_ff    <= btn_rd[low_idx];
         out_status_ff <= ST_OK;
         out_last_ff   <= event_last;
         for (int i = 0; i < LED_LANES; i++) begin
            out_led_ff[i] <= 8'h00;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cathode_drive = out_drive_ff;
   assign rsp_led_left_c0   = out_led_ff[0];
   assign rsp_led_right_c0  = out_led_ff[1];
   assign rsp_led_left_c1   = out_led_ff[2];
   assign rsp_led_right_c1  = out_led_ff[3];
   assign rsp_led_left_c2   = out_led_ff[4];
   assign rsp_led_right_c2  = out_led_ff[5];
   assign rsp_read_data     = out_read_ff;
   assign rsp_event_pin     = out_pin_ff;
   assign rsp_event_value   = out_val_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_last          = out_last_ff;

   // ---------------------------------------------------------------- status
   assign stat.req_type   = lat_type_ff;
   assign stat.req_err    = (req_status != ST_OK);
   assign stat.led_done   = (int'(slot_ff) == LED_READS);
   assign stat.out_free   = out_free;
   assign stat.row_empty  = (flags_rd == 8'h00);
   assign stat.event_last = event_last;

endmodule

// ===== tb/button_led_matrix_scanner_tb.sv =====
module button_led_matrix_scanner_tb;
   import blms_pkg::*;

   localparam int NCOL          = NUM_COLOURS_DEF;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 36;     // counted items per random phase
   localparam int QUIET_PHASE   = 4;      // no gaps, no stalls
   localparam int HOLD_PHASE    = 5;      // receiver backs off for a long stretch
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 100;    // idle wait after the last result is in

   // codes the block drops without a result
   localparam logic [2:0] REQ_UNUSED_A = 3'd6;
   localparam logic [2:0] REQ_UNUSED_B = 3'd7;

   typedef struct {
      logic [2:0] kind;
      logic [7:0] din_left;
      logic [7:0] din_right;
      logic [1:0] colour;
      logic [7:0] pin;
      logic [3:0] row;
      logic [7:0] value;
   } request_t;

   typedef struct packed {
      logic [7:0]      cathode;
      logic [2:0][7:0] led_left;
      logic [2:0][7:0] led_right;
      logic [7:0]      read_data;
      logic [5:0]      event_pin;
      logic            event_value;
      logic [1:0]      status;
      logic            last;
   } result_t;

   // Mirror of the scanner state: LED planes, debounced buttons, change
   // flags, the shared debounce counter and the three registers. Each
   // accepted item is folded in here and its results are queued in order.
   class matrix_mirror;
      bit [7:0] delay_reg;
      bit [7:0] invert_reg;
      bit [1:0] din_en_reg;
      bit [1:0] column;
      bit [7:0] buttons [ROWS];
      bit [7:0] changed [ROWS];
      bit [7:0] leds [NCOL*ROWS];
      bit [7:0] debounce;
      result_t  pending_results [$];
      int       failures;

      function void clear();
         delay_reg  = 8'd0;
         invert_reg = 8'd0;
         din_en_reg = DIN_ENABLE_RST;
         column     = 2'd0;
         debounce   = 8'd0;
         foreach (buttons[i]) buttons[i] = ABSENT_BYTE;
         foreach (changed[i]) changed[i] = 8'd0;
         foreach (leds[i]) leds[i] = 8'd0;
         pending_results.delete();
         failures = 0;
      endfunction

      function void set_register(logic [1:0] index, logic [31:0] data);
         case (index)
            CSR_DEBOUNCE_DELAY: delay_reg  = data[7:0];
            CSR_CATHODE_INVERT: invert_reg = data[7:0];
            CSR_DIN_ENABLE:     din_en_reg = data[1:0];
            default: ;
         endcase
      endfunction

      function void note_request(request_t rq);
         result_t  r;
         bit [3:0] sel;
         bit [2:0] brow;
         bit [1:0] prev;
         bit [7:0] level;
         bit [7:0] diff;
         int       idx;
         int       total;
         int       emitted;
         r      = '0;
         r.last = 1'b1;
         case (rq.kind)
            REQ_SCAN: begin
               column    = column + 2'd1;
               sel       = (4'b0001 << column) ^ NIBBLE_MASK;
               r.cathode = {sel, sel} ^ invert_reg;
               for (int c = 0; c < NCOL; c++) begin
                  r.led_left[c]  = leds[c*ROWS + column*2];
                  r.led_right[c] = leds[c*ROWS + column*2 + 1];
               end
               // one counter for both sides; a left change masks the right
               if (debounce != 0)
                  debounce--;
               prev = column - 2'd1;
               for (int side = 0; side < 2; side++) begin
                  brow  = {prev, 1'(side)};
                  level = ABSENT_BYTE;
                  if (din_en_reg[side])
                     level = (side == 0) ? rq.din_left : rq.din_right;
                  if (debounce == 0) begin
                     diff           = level ^ buttons[brow];
                     changed[brow] |= diff;
                     buttons[brow]  = level;
                     if (diff != 0)
                        debounce = delay_reg;
                  end
               end
               pending_results.push_back(r);
            end
            REQ_BIT_WR: begin
               if (rq.pin >= 8'd64)
                  r.status = ST_RANGE;
               else if (rq.colour >= NCOL)
                  r.status = ST_COLOUR;
               else begin
                  idx = rq.colour*ROWS + rq.pin[5:3];
                  leds[idx][rq.pin[2:0]] = rq.value[0];
               end
               pending_results.push_back(r);
            end
            REQ_ROW_WR, REQ_ROW_RD: begin
               idx = rq.colour*ROWS + rq.row;
               if (rq.row >= ROWS)
                  r.status = ST_RANGE;
               else if (rq.colour >= NCOL)
                  r.status = ST_COLOUR;
               else if (rq.kind == REQ_ROW_WR)
                  leds[idx] = rq.value;
               else
                  r.read_data = leds[idx];
               pending_results.push_back(r);
            end
            REQ_BTN_RD: begin
               if (rq.row >= ROWS)
                  r.status = ST_RANGE;
               else
                  r.read_data = buttons[rq.row[2:0]];
               pending_results.push_back(r);
            end
            REQ_DRAIN: begin
               total = 0;
               foreach (changed[i]) total += $countones(changed[i]);
               if (total == 0) begin
                  r.status = ST_NO_EVENT;
                  pending_results.push_back(r);
               end else begin
                  // lowest row, lowest bit first; flags cleared as walked
                  emitted = 0;
                  for (int i = 0; i < ROWS; i++) begin
                     for (int b = 0; b < 8; b++) begin
                        if (changed[i][b]) begin
                           emitted++;
                           r             = '0;
                           r.event_pin   = 6'(i*8 + b);
                           r.event_value = buttons[i][b];
                           r.last        = (emitted == total);
                           pending_results.push_back(r);
                        end
                     end
                     changed[i] = 8'd0;
                  end
               end
            end
            default: ;
         endcase
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            failures++;
         end
      endfunction

      function void check_result(result_t got);
         result_t want;
         if (pending_results.size() == 0) begin
            $display("%0t: result with nothing outstanding, status %0d", $time, got.status);
            failures++;
            return;
         end
         want = pending_results.pop_front();
         compare_field("cathode_drive", want.cathode, got.cathode);
         for (int c = 0; c < 3; c++) begin
            compare_field($sformatf("led_left_c%0d", c), want.led_left[c], got.led_left[c]);
            compare_field($sformatf("led_right_c%0d", c), want.led_right[c], got.led_right[c]);
         end
         compare_field("read_data", want.read_data, got.read_data);
         compare_field("event_pin", want.event_pin, got.event_pin);
         compare_field("event_value", want.event_value, got.event_value);
         compare_field("status", want.status, got.status);
         compare_field("last", want.last, got.last);
      endfunction
   endclass

   // ---------------------------------------------------------------------
   // Signals; every block input starts at a known value
   // ---------------------------------------------------------------------
   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [2:0]        req_type      = REQ_SCAN;
   logic [7:0]        req_din_left  = 8'd0;
   logic [7:0]        req_din_right = 8'd0;
   logic [1:0]        req_colour    = 2'd0;
   logic [7:0]        req_pin       = 8'd0;
   logic [3:0]        req_row       = 4'd0;
   logic [7:0]        req_value     = 8'd0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [7:0]        rsp_cathode_drive;
   logic [7:0]        rsp_led_left_c0;
   logic [7:0]        rsp_led_right_c0;
   logic [7:0]        rsp_led_left_c1;
   logic [7:0]        rsp_led_right_c1;
   logic [7:0]        rsp_led_left_c2;
   logic [7:0]        rsp_led_right_c2;
   logic [7:0]        rsp_read_data;
   logic [5:0]        rsp_event_pin;
   logic              rsp_event_value;
   logic [1:0]        rsp_status;
   logic              rsp_last;
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0] csr_paddr   = '0;
   logic [CSR_DW-1:0] csr_pwdata  = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   matrix_mirror mirror;
   request_t     stim_q [$];

   // Per-slot button bytes held between scans so the debouncer sees steady
   // input often enough to commit changes.
   bit [7:0] held_left [4]  = '{default: 8'hff};
   bit [7:0] held_right [4] = '{default: 8'hff};
   int       scan_slot      = 0;

   bit       quiet_phase = 1'b0;
   int       hold_asks   = 0;     // bumped to request one long receiver hold-off

   // Register settings per random phase: both extremes of delay and mask,
   // every din_enable combination.
   bit [7:0] phase_delay  [PHASES] = '{8'd0, 8'd2, 8'd255, 8'd1, 8'd0, 8'd4};
   bit [7:0] phase_invert [PHASES] = '{8'hff, 8'h5a, 8'h00, 8'ha5, 8'h3c, 8'h0f};
   bit [1:0] phase_din_en [PHASES] = '{2'd3, 2'd1, 2'd0, 2'd2, 2'd3, 2'd3};

   always #4 clock = ~clock;

   button_led_matrix_scanner dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_din_left      (req_din_left),
      .req_din_right     (req_din_right),
      .req_colour        (req_colour),
      .req_pin           (req_pin),
      .req_row           (req_row),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_cathode_drive (rsp_cathode_drive),
      .rsp_led_left_c0   (rsp_led_left_c0),
      .rsp_led_right_c0  (rsp_led_right_c0),
      .rsp_led_left_c1   (rsp_led_left_c1),
      .rsp_led_right_c1  (rsp_led_right_c1),
      .rsp_led_left_c2   (rsp_led_left_c2),
      .rsp_led_right_c2  (rsp_led_right_c2),
      .rsp_read_data     (rsp_read_data),
      .rsp_event_pin     (rsp_event_pin),
      .rsp_event_value   (rsp_event_value),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic void add_req(logic [2:0] kind, logic [1:0] colour, logic [7:0] pin,
                                   logic [3:0] row, logic [7:0] value,
                                   logic [7:0] din_l, logic [7:0] din_r);
      request_t rq;
      rq.kind      = kind;
      rq.colour    = colour;
      rq.pin       = pin;
      rq.row       = row;
      rq.value     = value;
      rq.din_left  = din_l;
      rq.din_right = din_r;
      stim_q.push_back(rq);
   endfunction

   function automatic request_t random_request();
      request_t rq;
      int       roll;
      int       slot;
      rq.din_left  = 8'($urandom);
      rq.din_right = 8'($urandom);
      rq.colour    = 2'($urandom);
      rq.pin       = 8'($urandom);
      rq.row       = 4'($urandom);
      rq.value     = 8'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 38)
         rq.kind = REQ_SCAN;
      else if (roll < 52)
         rq.kind = REQ_BIT_WR;
      else if (roll < 62)
         rq.kind = REQ_ROW_WR;
      else if (roll < 74)
         rq.kind = REQ_ROW_RD;
      else if (roll < 84)
         rq.kind = REQ_BTN_RD;
      else if (roll < 96)
         rq.kind = REQ_DRAIN;
      else
         rq.kind = $urandom_range(0, 1) ? REQ_UNUSED_A : REQ_UNUSED_B;
      // nine in ten land in range so they reach the stores
      if ($urandom_range(0, 9) != 0) begin
         rq.pin[7:6] = 2'b00;
         rq.row[3]   = 1'b0;
         if (rq.colour >= NCOL)
            rq.colour = 2'($urandom_range(0, NCOL - 1));
      end
      if (rq.kind == REQ_SCAN) begin
         // mostly repeat the slot's bytes, sometimes flip one bit or replace
         slot = scan_slot % 4;
         scan_slot++;
         roll = $urandom_range(0, 99);
         if (roll < 25) begin
            if ($urandom_range(0, 1))
               held_left[slot] ^= 8'(1 << $urandom_range(0, 7));
            else
               held_right[slot] ^= 8'(1 << $urandom_range(0, 7));
         end else if (roll < 40) begin
            held_left[slot]  = rq.din_left;
            held_right[slot] = rq.din_right;
         end
         rq.din_left  = held_left[slot];
         rq.din_right = held_right[slot];
      end
      return rq;
   endfunction

   // Offer queued items one by one, with random gaps before each. The item
   // is folded into the mirror at the edge it is taken.
   task automatic send_items();
      request_t rq;
      int       gap;
      int       roll;
      while (stim_q.size() > 0) begin
         rq   = stim_q.pop_front();
         roll = $urandom_range(0, 99);
         if (quiet_phase || roll < 50)
            gap = 0;
         else if (roll < 90)
            gap = $urandom_range(1, 3);
         else
            gap = $urandom_range(8, 30);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_type      <= rq.kind;
         req_din_left  <= rq.din_left;
         req_din_right <= rq.din_right;
         req_colour    <= rq.colour;
         req_pin       <= rq.pin;
         req_row       <= rq.row;
         req_value     <= rq.value;
         req_valid     <= 1'b1;
         do @(posedge clock); while (req_stall);
         mirror.note_request(rq);
      end
      req_valid <= 1'b0;
   endtask

   // One APB transfer; a read is checked against data. The task drops psel
   // before it returns so back-to-back calls never double-drive psel.
   task automatic csr_access(input logic [1:0] index, input logic write,
                             input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= write ? data : '0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (write)
         mirror.set_register(index, data);
      else if (csr_prdata !== data) begin
         $display("%0t: register %0d read mismatch, expected %0h, got %0h",
                  $time, index, data, csr_prdata);
         mirror.failures++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_register(input logic [1:0] index, input logic [31:0] data);
      csr_access(index, 1'b1, data);
      csr_access(index, 1'b0, data);
   endtask

   // Idle point: all results in, then room for a dropped code still in flight.
   task automatic settle();
      while (mirror.pending_results.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Result side: check every taken result, stall at random. A hold-off
   // request keeps it stalling until a HOLD_CYCLES countdown ends, so the
   // block backs up into req_stall while the sender keeps offering.
   // ---------------------------------------------------------------------
   initial begin : result_sink
      result_t got;
      int      hold_left;
      int      asks_seen;
      int      roll;
      hold_left = 0;
      asks_seen = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
            got.cathode      = rsp_cathode_drive;
            got.led_left[0]  = rsp_led_left_c0;
            got.led_right[0] = rsp_led_right_c0;
            got.led_left[1]  = rsp_led_left_c1;
            got.led_right[1] = rsp_led_right_c1;
            got.led_left[2]  = rsp_led_left_c2;
            got.led_right[2] = rsp_led_right_c2;
            got.read_data    = rsp_read_data;
            got.event_pin    = rsp_event_pin;
            got.event_value  = rsp_event_value;
            got.status       = rsp_status;
            got.last         = rsp_last;
            mirror.check_result(got);
         end
         if (hold_asks != asks_seen) begin
            asks_seen = hold_asks;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (quiet_phase) begin
            rsp_stall <= 1'b0;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 60)
               rsp_stall <= 1'b0;
            else begin
               rsp_stall <= 1'b1;
               hold_left = (roll < 95) ? $urandom_range(0, 3) : $urandom_range(8, 40);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main flow: reset, register reset values, directed items at reset
   // settings, then random phases, each under its own register settings.
   // ---------------------------------------------------------------------
   initial begin : main_flow
      request_t rq;
      int       counted;
      mirror = new;
      mirror.clear();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_access(CSR_DEBOUNCE_DELAY, 1'b0, 32'd0);
      csr_access(CSR_CATHODE_INVERT, 1'b0, 32'd0);
      csr_access(CSR_DIN_ENABLE, 1'b0, 32'(DIN_ENABLE_RST));

      // reads of reset state; out-of-range row (colour ignored); empty drain
      add_req(REQ_BTN_RD, 2'd0, 8'd0, 4'd0, 8'd0, 8'd0, 8'd0);
      add_req(REQ_BTN_RD, 2'd3, 8'd0, 4'd15, 8'd0, 8'd0, 8'd0);
      add_req(REQ_ROW_RD, 2'd0, 8'd0, 4'd0, 8'd0, 8'd0, 8'd0);
      add_req(REQ_DRAIN, 2'd0, 8'd0, 4'd0, 8'd0, 8'd0, 8'd0);
      // row writes; bad colour; bad row wins over bad colour
      add_req(REQ_ROW_WR, 2'd0, 8'd0, 4'd0, 8'hff, 8'd0, 8'd0);
      add_req(REQ_ROW_WR, 2'd2, 8'd0, 4'd7, 8'h81, 8'd0, 8'd0);
      add_req(REQ_ROW_WR, 2'd3, 8'd0, 4'd2, 8'h55, 8'd0, 8'd0);
      add_req(REQ_ROW_WR, 2'd3, 8'd0, 4'd15, 8'haa, 8'd0, 8'd0);
      // bit set on the top pin, bit clear on pin 0, range and colour errors
      add_req(REQ_BIT_WR, 2'd1, 8'd63, 4'd0, 8'h01, 8'd0, 8'd0);
      add_req(REQ_BIT_WR, 2'd0, 8'd0, 4'd0, 8'hfe, 8'd0, 8'd0);
      add_req(REQ_BIT_WR, 2'd0, 8'd64, 4'd0, 8'h01, 8'd0, 8'd0);
      add_req(REQ_BIT_WR, 2'd3, 8'd255, 4'd0, 8'h01, 8'd0, 8'd0);
      add_req(REQ_BIT_WR, 2'd3, 8'd5, 4'd0, 8'h01, 8'd0, 8'd0);
      add_req(REQ_ROW_RD, 2'd0, 8'd0, 4'd0, 8'd0, 8'd0, 8'd0);
      add_req(REQ_ROW_RD, 2'd1, 8'd0, 4'd7, 8'd0, 8'd0, 8'd0);
      add_req(REQ_ROW_RD, 2'd2, 8'd0, 4'd8, 8'd0, 8'd0, 8'd0);
      // four scans wrap the column and pick up the LED rows written above
      add_req(REQ_SCAN, 2'd0, 8'd0, 4'd0, 8'd0, 8'h00, 8'hff);
      add_req(REQ_SCAN, 2'd0, 8'd0, 4'd0, 8'd0, 8'hff, 8'h00);
      add_req(REQ_SCAN, 2'd0, 8'd0, 4'd0, 8'd0, 8'ha5, 8'h5a);
      add_req(REQ_SCAN, 2'd0, 8'd0, 4'd0, 8'd0, 8'hff, 8'hff);
      // dropped codes, then a drain with many events
      add_req(REQ_UNUSED_A, 2'd0, 8'd0, 4'd0, 8'd0, 8'd0, 8'd0);
      add_req(REQ_UNUSED_B, 2'd3, 8'hff, 4'd15, 8'hff, 8'hff, 8'hff);
      add_req(REQ_DRAIN, 2'd0, 8'd0, 4'd0, 8'd0, 8'd0, 8'd0);
      add_req(REQ_BTN_RD, 2'd1, 8'd0, 4'd3, 8'd0, 8'd0, 8'd0);
      add_req(REQ_SCAN, 2'd0, 8'd0, 4'd0, 8'd0, 8'h00, 8'h00);
      send_items();
      settle();

      for (int p = 0; p < PHASES; p++) begin
         program_register(CSR_DEBOUNCE_DELAY, 32'(phase_delay[p]));
         program_register(CSR_CATHODE_INVERT, 32'(phase_invert[p]));
         program_register(CSR_DIN_ENABLE, 32'(phase_din_en[p]));
         quiet_phase <= (p == QUIET_PHASE);
         if (p == HOLD_PHASE)
            hold_asks <= hold_asks + 1;
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            rq = random_request();
            stim_q.push_back(rq);
            if (rq.kind <= REQ_DRAIN)
               counted++;
         end
         send_items();
         settle();
      end

      if (mirror.failures == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin : watchdog
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
